### sv/turtle_vector_command_engine_assert.svh
`ifndef TURTLE_VECTOR_COMMAND_ENGINE_ASSERT_SVH
`define TURTLE_VECTOR_COMMAND_ENGINE_ASSERT_SVH
// Implication checked on every clock edge outside reset
`define TVCE_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Implication whose consequence is checked in the cycle after the antecedent
`define TVCE_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

### sv/tvce_pkg.sv
package tvce_pkg;

  typedef enum logic [3:0] {
    CMD_RESET   = 4'd0,
    CMD_STEP    = 4'd1,
    CMD_MOVE    = 4'd2,
    CMD_JUMP    = 4'd3,
    CMD_SETX    = 4'd4,
    CMD_SETY    = 4'd5,
    CMD_LEFT    = 4'd6,
    CMD_RIGHT   = 4'd7,
    CMD_SETHEAD = 4'd8,
    CMD_PEN     = 4'd9,
    CMD_PUSH    = 4'd10,
    CMD_POP     = 4'd11
  } cmd_t;

  localparam logic [1:0] ERR_OK        = 2'd0;
  localparam logic [1:0] ERR_PUSH_FULL = 2'd1;
  localparam logic [1:0] ERR_POP_EMPTY = 2'd2;

  localparam logic [1:0] REG_START_X    = 2'd0;
  localparam logic [1:0] REG_START_Y    = 2'd1;
  localparam logic [1:0] REG_START_HEAD = 2'd2;
  localparam logic [1:0] REG_START_PEN  = 2'd3;

  localparam logic signed [33:0] CORDIC_INV_GAIN = 34'sh026DD3B6A;
  localparam int AtanEntries = 24;

  // Controller to datapath commands
  typedef struct packed {
    logic latch;       // capture input item and apply simple command
    logic cordic_init; // load CORDIC start values
    logic cordic_iter; // one CORDIC iteration
    logic mul_x;       // cos * distance
    logic mul_y;       // sin * distance
    logic step_fin;    // apply step offsets
    logic push_wr;     // write stack entry
    logic pop_rd;      // issue stack read
    logic pop_fin;     // load popped state
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic stack_empty;
    logic stack_full;
  } dp_stat_t;

  function automatic logic [31:0] atan_lut(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

endpackage

### sv/tvce_ctrl.sv
module tvce_ctrl #(
  parameter int TRIG_ITERATIONS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  logic [3:0]          cmd,
  input  tvce_pkg::dp_stat_t  stat,
  input  logic                out_free,
  output tvce_pkg::dp_cmd_t   dcmd,
  output logic                busy,
  output logic                res_load
);
  typedef enum logic [2:0] {
    S_IDLE, S_ITER, S_MULX, S_MULY, S_STEPF, S_POPRD, S_POPF, S_DONE
  } state_t;

  localparam int ItW = $clog2(TRIG_ITERATIONS + 1);
  localparam logic [ItW-1:0] ItLast = ItW'(TRIG_ITERATIONS - 1);

  state_t         state_r, state_nxt;
  logic [ItW-1:0] it_r, it_nxt;

  always_comb begin
    state_nxt = state_r;
    it_nxt    = it_r;
    dcmd      = '0;
    res_load  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          dcmd.latch = 1'b1;
          case (cmd)
            tvce_pkg::CMD_STEP: begin
              dcmd.cordic_init = 1'b1;
              it_nxt = '0;
              state_nxt = S_ITER;
            end
            tvce_pkg::CMD_POP: begin
              state_nxt = stat.stack_empty ? S_DONE : S_POPRD;
            end
            tvce_pkg::CMD_PUSH: begin
              dcmd.push_wr = !stat.stack_full;
              state_nxt = S_DONE;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_ITER: begin
        dcmd.cordic_iter = 1'b1;
        it_nxt = it_r + 1'b1;
        if (it_r == ItLast) state_nxt = S_MULX;
      end
      S_MULX: begin
        dcmd.mul_x = 1'b1;
        state_nxt = S_MULY;
      end
      S_MULY: begin
        dcmd.mul_y = 1'b1;
        state_nxt = S_STEPF;
      end
      S_STEPF: begin
        dcmd.step_fin = 1'b1;
        state_nxt = S_DONE;
      end
      S_POPRD: begin
        dcmd.pop_rd = 1'b1;
        state_nxt = S_POPF;
      end
      S_POPF: begin
        dcmd.pop_fin = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          res_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      it_r    <= '0;
    end else begin
      state_r <= state_nxt;
      it_r    <= it_nxt;
    end
  end
endmodule

### sv/tvce_datapath.sv
module tvce_datapath #(
  parameter int STACK_DEPTH     = 64,
  parameter int TRIG_ITERATIONS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tvce_pkg::dp_cmd_t  dcmd,
  output tvce_pkg::dp_stat_t stat,
  input  logic [3:0]         in_cmd,
  input  logic [31:0]        in_distance,
  input  logic [31:0]        in_x,
  input  logic [31:0]        in_y,
  input  logic [15:0]        in_angle,
  input  logic               in_penv,
  input  logic [31:0]        start_x,
  input  logic [31:0]        start_y,
  input  logic [15:0]        start_heading,
  input  logic               start_pen,
  output logic               res_seg,
  output logic [31:0]        res_x0,
  output logic [31:0]        res_y0,
  output logic [31:0]        res_x,
  output logic [31:0]        res_y,
  output logic [15:0]        res_heading,
  output logic               res_pen,
  output logic [1:0]         res_err
);
  localparam int CntW = $clog2(STACK_DEPTH + 1);
  localparam int AddrW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int ItW = $clog2(TRIG_ITERATIONS + 1);

  // Architectural turtle state
  logic [31:0] cur_x_r, cur_y_r;
  logic [15:0] cur_h_r;
  logic        cur_pen_r;
  logic [CntW-1:0] cnt_r;

  // Per-item registers
  logic [31:0] dist_r, ox_r, oy_r;
  logic        seg_r, flip_r;
  logic [1:0]  err_r;

  // CORDIC state
  logic signed [33:0] cx_r, cy_r;
  logic signed [32:0] cz_r;
  logic [ItW-1:0]     it_r;
  logic signed [65:0] prod_r;

  // Stack memory
  logic [80:0] stack_mem [STACK_DEPTH];
  logic [80:0] rd_r;

  assign stat.stack_empty = (cnt_r == '0);
  assign stat.stack_full  = (cnt_r >= CntW'(STACK_DEPTH));

  function automatic logic [AddrW-1:0] to_addr(input logic [CntW-1:0] v);
    logic [CntW+AddrW-1:0] w;
    w = {{AddrW{1'b0}}, v};
    return w[AddrW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (dcmd.push_wr)
      stack_mem[to_addr(cnt_r)] <= {cur_x_r, cur_y_r, cur_h_r, cur_pen_r};
    if (dcmd.pop_rd) rd_r <= stack_mem[to_addr(cnt_r)];
  end

  // Segment flag and error code of the item being taken
  logic       seg_nxt;
  logic [1:0] err_nxt;
  always_comb begin
    seg_nxt = (in_cmd inside {tvce_pkg::CMD_STEP, tvce_pkg::CMD_MOVE}) && cur_pen_r;
    err_nxt = tvce_pkg::ERR_OK;
    if (in_cmd == tvce_pkg::CMD_PUSH && stat.stack_full)
      err_nxt = tvce_pkg::ERR_PUSH_FULL;
    else if (in_cmd == tvce_pkg::CMD_POP && stat.stack_empty)
      err_nxt = tvce_pkg::ERR_POP_EMPTY;
  end

  // CORDIC setup and iteration
  logic [31:0] z32;
  logic        flip;
  logic signed [33:0] xs, ys;
  logic signed [32:0] at;
  always_comb begin
    z32  = {cur_h_r, 16'h0};
    flip = cur_h_r[15] ^ cur_h_r[14];
    if (flip) z32 = z32 - 32'h80000000;
    xs = cx_r >>> it_r;
    ys = cy_r >>> it_r;
    at = $signed({1'b0, tvce_pkg::atan_lut(5'(it_r))});
  end

  // Step offset: (trig*dist + 2^29) >>> 30, then saturating add
  logic signed [65:0] off66;
  logic signed [35:0] off;
  logic [31:0] sat;
  always_comb begin
    off66 = prod_r + 66'sd536870912;
    off   = off66[65:30];
  end

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic signed [35:0] d,
                                          input logic neg);
    logic signed [36:0] s;
    s = neg ? ($signed({{5{a[31]}}, a}) - d) : ($signed({{5{a[31]}}, a}) + d);
    if (s > 37'sd2147483647) return 32'h7FFFFFFF;
    if (s < -37'sd2147483648) return 32'h80000000;
    return s[31:0];
  endfunction

  assign sat = sat_add(cur_x_r, off, 1'b0);

  logic signed [33:0] cos_v, sin_v;
  assign cos_v = flip_r ? -cx_r : cx_r;
  assign sin_v = flip_r ? -cy_r : cy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r   <= '0;
      cur_y_r   <= '0;
      cur_h_r   <= '0;
      cur_pen_r <= 1'b0;
      cnt_r     <= '0;
    end else begin
      if (dcmd.latch) begin
        ox_r   <= cur_x_r;
        oy_r   <= cur_y_r;
        dist_r <= in_distance;
        seg_r  <= seg_nxt;
        err_r  <= err_nxt;
        case (in_cmd)
          tvce_pkg::CMD_RESET: begin
            cur_x_r <= start_x; cur_y_r <= start_y;
            cur_h_r <= start_heading; cur_pen_r <= start_pen;
          end
          tvce_pkg::CMD_MOVE: begin
            cur_x_r <= in_x; cur_y_r <= in_y;
          end
          tvce_pkg::CMD_JUMP: begin
            cur_x_r <= in_x; cur_y_r <= in_y;
          end
          tvce_pkg::CMD_SETX:    cur_x_r <= in_x;
          tvce_pkg::CMD_SETY:    cur_y_r <= in_y;
          tvce_pkg::CMD_LEFT:    cur_h_r <= cur_h_r + in_angle;
          tvce_pkg::CMD_RIGHT:   cur_h_r <= cur_h_r - in_angle;
          tvce_pkg::CMD_SETHEAD: cur_h_r <= in_angle;
          tvce_pkg::CMD_PEN:     cur_pen_r <= in_penv;
          tvce_pkg::CMD_PUSH: begin
            if (!stat.stack_full) cnt_r <= cnt_r + 1'b1;
          end
          tvce_pkg::CMD_POP: begin
            if (!stat.stack_empty) cnt_r <= cnt_r - 1'b1;
          end
          default: ;
        endcase
      end
      if (dcmd.cordic_init) begin
        cx_r   <= tvce_pkg::CORDIC_INV_GAIN;
        cy_r   <= '0;
        cz_r   <= $signed({z32[31], z32});
        flip_r <= flip;
        it_r   <= '0;
      end
      if (dcmd.cordic_iter) begin
        if (!cz_r[32]) begin
          cx_r <= cx_r - ys; cy_r <= cy_r + xs; cz_r <= cz_r - at;
        end else begin
          cx_r <= cx_r + ys; cy_r <= cy_r - xs; cz_r <= cz_r + at;
        end
        it_r <= it_r + 1'b1;
      end
      if (dcmd.mul_x) prod_r <= 66'(cos_v * $signed(dist_r));
      if (dcmd.mul_y) begin
        cur_x_r <= sat;
        prod_r  <= 66'(sin_v * $signed(dist_r));
      end
      if (dcmd.step_fin) cur_y_r <= sat_add(cur_y_r, off, 1'b1);
      if (dcmd.pop_fin) begin
        cur_x_r   <= rd_r[80:49];
        cur_y_r   <= rd_r[48:17];
        cur_h_r   <= rd_r[16:1];
        cur_pen_r <= rd_r[0];
      end
    end
  end

  assign res_seg     = seg_r;
  assign res_x0      = seg_r ? ox_r : 32'h0;
  assign res_y0      = seg_r ? oy_r : 32'h0;
  assign res_x       = cur_x_r;
  assign res_y       = cur_y_r;
  assign res_heading = cur_h_r;
  assign res_pen     = cur_pen_r;
  assign res_err     = err_r;
endmodule

### sv/turtle_vector_command_engine.sv
// Turtle command engine: one command item in, one result item out. Simple
// commands finish directly; pop reads the stack entry and then loads the
// popped state. A step runs TRIG_ITERATIONS iterations in the CORDIC iteration
// unit, one iteration a cycle, followed by a multiply for the cos offset, a
// multiply for the sin offset that also applies the x update, and the final y
// update. The result item becomes valid in the same cycle that the next item
// can be taken. One item is in work at a time; the next is taken once the
// result register has been loaded, so a stalled result stalls the input. Start
// registers apply at the next reset command. Push on a full stack and pop on
// an empty one report an error and change nothing.
`include "turtle_vector_command_engine_assert.svh"
module turtle_vector_command_engine #(
  parameter int STACK_DEPTH     = 64,
  parameter int TRIG_ITERATIONS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // cmd[3:0], distance[35:4], x_coord[67:36], y_coord[99:68],
  // angle_value[115:100], pen_value[116], zero fill
  input  logic [119:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // segment_valid[0], seg_x0[32:1], seg_y0[64:33], seg_x1[96:65],
  // seg_y1[128:97], pos_x[160:129], pos_y[192:161], heading[208:193],
  // pen[209], error_code[211:210], zero fill
  output logic [215:0] out_tdata,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [3:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  tvce_pkg::dp_cmd_t  dcmd;
  tvce_pkg::dp_stat_t stat;
  logic busy, res_load, in_fire;
  logic [31:0] start_x_r, start_y_r;
  logic [15:0] start_h_r;
  logic        start_pen_r;
  logic        res_seg, res_pen;
  logic [31:0] res_x0, res_y0, res_x, res_y;
  logic [15:0] res_h;
  logic [1:0]  res_err;
  logic        out_valid_r;
  logic [215:0] out_data_r;
  logic [1:0]  reg_idx;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[3:2];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_x_r <= '0; start_y_r <= '0; start_h_r <= '0; start_pen_r <= 1'b0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      case (reg_idx)
        tvce_pkg::REG_START_X:    start_x_r <= cfg_pwdata;
        tvce_pkg::REG_START_Y:    start_y_r <= cfg_pwdata;
        tvce_pkg::REG_START_HEAD: start_h_r <= cfg_pwdata[15:0];
        tvce_pkg::REG_START_PEN:  start_pen_r <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      tvce_pkg::REG_START_X:    cfg_prdata = start_x_r;
      tvce_pkg::REG_START_Y:    cfg_prdata = start_y_r;
      tvce_pkg::REG_START_HEAD: cfg_prdata = {16'h0, start_h_r};
      tvce_pkg::REG_START_PEN:  cfg_prdata = {31'h0, start_pen_r};
      default:                  cfg_prdata = '0;
    endcase
  end

  assign in_tready = !busy;
  assign in_fire   = in_tvalid && in_tready;

  tvce_ctrl #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .cmd(in_tdata[3:0]),
    .stat(stat), .out_free(!out_valid_r || out_tready),
    .dcmd(dcmd), .busy(busy), .res_load(res_load)
  );

  tvce_datapath #(.STACK_DEPTH(STACK_DEPTH), .TRIG_ITERATIONS(TRIG_ITERATIONS)) u_dp (
    .clk(clk), .rst_n(rst_n), .dcmd(dcmd), .stat(stat),
    .in_cmd(in_tdata[3:0]), .in_distance(in_tdata[35:4]),
    .in_x(in_tdata[67:36]), .in_y(in_tdata[99:68]),
    .in_angle(in_tdata[115:100]), .in_penv(in_tdata[116]),
    .start_x(start_x_r), .start_y(start_y_r),
    .start_heading(start_h_r), .start_pen(start_pen_r),
    .res_seg(res_seg), .res_x0(res_x0), .res_y0(res_y0), .res_x(res_x),
    .res_y(res_y), .res_heading(res_h), .res_pen(res_pen), .res_err(res_err)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load)
      out_data_r <= {4'h0, res_err, res_pen, res_h, res_y, res_x,
                     res_seg ? res_y : 32'h0, res_seg ? res_x : 32'h0,
                     res_y0, res_x0, res_seg};
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `TVCE_ASSERT_IMP(a_no_accept_busy, busy, !in_tready)
  `TVCE_ASSERT_NXT(a_load_valid, res_load, out_tvalid)
  `TVCE_ASSERT_IMP(a_err_code, out_tvalid, out_tdata[211:210] <= tvce_pkg::ERR_POP_EMPTY)
endmodule

### tb/sv/tb_turtle_vector_command_engine.sv
module tb_turtle_vector_command_engine;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StackDepth = 64;
  localparam int TrigIters  = 16;
  localparam int IdleLimit  = 20000;

  typedef struct packed {
    logic [1:0]  err;
    logic        pen;
    logic [15:0] heading;
    logic [31:0] pos_y;
    logic [31:0] pos_x;
    logic [31:0] y1;
    logic [31:0] x1;
    logic [31:0] y0;
    logic [31:0] x0;
    logic        seg;
  } turtle_result_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [119:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [215:0] out_tdata;
  logic         cfg_psel;
  logic         cfg_penable;
  logic         cfg_pwrite;
  logic [3:0]   cfg_paddr;
  logic [31:0]  cfg_pwdata;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  turtle_vector_command_engine #(
    .STACK_DEPTH(StackDepth),
    .TRIG_ITERATIONS(TrigIters)
  ) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // Turtle state as predicted
  logic [31:0] start_x_q, start_y_q;
  logic [15:0] start_head_q;
  logic        start_pen_q;
  logic signed [31:0] turtle_x, turtle_y;
  logic [15:0] turtle_head;
  logic        turtle_pen;
  logic [63:0] saved_pos [StackDepth];
  logic [16:0] saved_hp [StackDepth];
  int          depth_used;

  turtle_result_t expected_results[$];
  int  error_count;
  int  idle_cycles;
  bit  idle_on;
  bit  hold_off;
  int  hold_cycles;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("error: %s got %h want %h", what, got, want);
    error_count++;
  endtask

  function automatic logic signed [63:0] floor_shift(input logic signed [63:0] v,
                                                     input int s);
    return v >>> s;
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Rotation CORDIC giving cos and sin of the heading in Q2.30
  task automatic heading_trig(input logic [15:0] h, output logic signed [63:0] c,
                              output logic signed [63:0] s);
    logic [31:0] z32;
    logic        flip;
    logic signed [63:0] x, y, z, xs, ys, at;
    z32 = {h, 16'h0};
    flip = ((h + 16'h4000) & 16'h8000) != 0;
    if (flip) z32 = z32 - 32'h80000000;
    z = {{32{z32[31]}}, z32};
    x = 64'sh26DD3B6A;
    y = '0;
    for (int i = 0; i < TrigIters && i < tvce_pkg::AtanEntries; i++) begin
      xs = floor_shift(x, i);
      ys = floor_shift(y, i);
      at = {32'h0, tvce_pkg::atan_lut(i[4:0])};
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - at;
      end else begin
        x = x + ys; y = y - xs; z = z + at;
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  // Apply one command to the predicted state and queue its result
  task automatic predict_command(input logic [3:0] cmd, input logic [31:0] distance,
                                 input logic [31:0] tx, input logic [31:0] ty,
                                 input logic [15:0] ang, input logic penv);
    turtle_result_t r;
    logic signed [31:0] ox, oy;
    logic signed [63:0] c, s, d;
    logic seg;
    logic [1:0] err;
    ox = turtle_x;
    oy = turtle_y;
    seg = 1'b0;
    err = tvce_pkg::ERR_OK;
    case (cmd)
      tvce_pkg::CMD_RESET: begin
        turtle_x = start_x_q; turtle_y = start_y_q;
        turtle_head = start_head_q; turtle_pen = start_pen_q;
      end
      tvce_pkg::CMD_STEP: begin
        heading_trig(turtle_head, c, s);
        d = $signed(distance);
        turtle_x = clamp32(64'(turtle_x) + floor_shift(c * d + (64'sd1 <<< 29), 30));
        turtle_y = clamp32(64'(turtle_y) - floor_shift(s * d + (64'sd1 <<< 29), 30));
        seg = turtle_pen;
      end
      tvce_pkg::CMD_MOVE: begin
        turtle_x = tx; turtle_y = ty; seg = turtle_pen;
      end
      tvce_pkg::CMD_JUMP: begin
        turtle_x = tx; turtle_y = ty;
      end
      tvce_pkg::CMD_SETX: turtle_x = tx;
      tvce_pkg::CMD_SETY: turtle_y = ty;
      tvce_pkg::CMD_LEFT: turtle_head = turtle_head + ang;
      tvce_pkg::CMD_RIGHT: turtle_head = turtle_head - ang;
      tvce_pkg::CMD_SETHEAD: turtle_head = ang;
      tvce_pkg::CMD_PEN: turtle_pen = penv;
      tvce_pkg::CMD_PUSH: begin
        if (depth_used >= StackDepth) begin
          err = tvce_pkg::ERR_PUSH_FULL;
        end else begin
          saved_pos[depth_used] = {turtle_x, turtle_y};
          saved_hp[depth_used] = {turtle_head, turtle_pen};
          depth_used++;
        end
      end
      tvce_pkg::CMD_POP: begin
        if (depth_used == 0) begin
          err = tvce_pkg::ERR_POP_EMPTY;
        end else begin
          depth_used--;
          {turtle_x, turtle_y} = saved_pos[depth_used];
          {turtle_head, turtle_pen} = saved_hp[depth_used];
        end
      end
      default: ;
    endcase
    r.seg = seg;
    r.x0 = seg ? ox : 32'h0;
    r.y0 = seg ? oy : 32'h0;
    r.x1 = seg ? turtle_x : 32'h0;
    r.y1 = seg ? turtle_y : 32'h0;
    r.pos_x = turtle_x;
    r.pos_y = turtle_y;
    r.heading = turtle_head;
    r.pen = turtle_pen;
    r.err = err;
    expected_results.push_back(r);
  endtask

  // Send one command item, with optional idle burst before it
  task automatic send_command(input logic [3:0] cmd, input logic [31:0] distance,
                              input logic [31:0] tx, input logic [31:0] ty,
                              input logic [15:0] ang, input logic penv);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = {3'b0, penv, ang, ty, tx, distance, cmd};
    predict_command(cmd, distance, tx, ty, ang, penv);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic send_simple(input logic [3:0] cmd, input logic [31:0] v);
    send_command(cmd, v, v, ~v, v[15:0], v[0]);
  endtask

  task automatic drain_results();
    while (expected_results.size() != 0) @(negedge clk);
    repeat (TrigIters + 12) @(negedge clk);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
    cfg_psel = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b1;
    cfg_paddr = {idx, 2'b00};
    cfg_pwdata = value;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    case (idx)
      tvce_pkg::REG_START_X: start_x_q = value;
      tvce_pkg::REG_START_Y: start_y_q = value;
      tvce_pkg::REG_START_HEAD: start_head_q = value[15:0];
      default: start_pen_q = value[0];
    endcase
  endtask

  task automatic set_start(input logic [31:0] x, input logic [31:0] y,
                           input logic [15:0] h, input logic p);
    drain_results();
    write_register(tvce_pkg::REG_START_X, x);
    write_register(tvce_pkg::REG_START_Y, y);
    write_register(tvce_pkg::REG_START_HEAD, {16'h0, h});
    write_register(tvce_pkg::REG_START_PEN, {31'h0, p});
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return $urandom_range(0, 32'h00FFFFFF) - 32'h00800000;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed_commands();
    set_start(32'h7FFFFFFF, 32'h80000000, 16'hFFFF, 1'b1);
    send_simple(tvce_pkg::CMD_RESET, 32'h0);
    send_command(tvce_pkg::CMD_STEP, 32'h7FFFFFFF, '0, '0, '0, 1'b0);
    send_command(tvce_pkg::CMD_STEP, 32'h80000000, '0, '0, '0, 1'b0);
    send_command(tvce_pkg::CMD_MOVE, '0, 32'h7FFFFFFF, 32'h7FFFFFFF, '0, 1'b0);
    send_command(tvce_pkg::CMD_JUMP, '0, 32'h80000000, 32'h80000000, '0, 1'b0);
    send_command(tvce_pkg::CMD_SETX, '0, 32'h00010000, '0, '0, 1'b0);
    send_command(tvce_pkg::CMD_SETY, '0, '0, 32'hFFFF0000, '0, 1'b0);
    send_command(tvce_pkg::CMD_LEFT, '0, '0, '0, 16'hFFFF, 1'b0);
    send_command(tvce_pkg::CMD_RIGHT, '0, '0, '0, 16'hFFFF, 1'b0);
    send_command(tvce_pkg::CMD_SETHEAD, '0, '0, '0, 16'h4000, 1'b0);
    send_command(tvce_pkg::CMD_STEP, 32'h00640000, '0, '0, '0, 1'b0);
    send_command(tvce_pkg::CMD_SETHEAD, '0, '0, '0, 16'hC000, 1'b0);
    send_command(tvce_pkg::CMD_STEP, 32'h00640000, '0, '0, '0, 1'b0);
    send_command(tvce_pkg::CMD_PEN, '0, '0, '0, '0, 1'b0);
    send_command(tvce_pkg::CMD_MOVE, '0, 32'h12345678, 32'h9ABCDEF0, '0, 1'b0);
    send_simple(tvce_pkg::CMD_POP, 32'h0);
    send_simple(tvce_pkg::CMD_PUSH, 32'h0);
    send_simple(tvce_pkg::CMD_POP, 32'h0);
    send_command(4'd12, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 1'b1);
    send_command(4'd15, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 1'b1);
    send_simple(tvce_pkg::CMD_RESET, 32'h0);
  endtask

  // Fill the stack past full and empty it past empty
  task automatic test_stack_limits();
    set_start(32'h0, 32'h0, 16'h0, 1'b0);
    send_simple(tvce_pkg::CMD_RESET, 32'h0);
    for (int i = 0; i < StackDepth + 2; i++) begin
      send_command(tvce_pkg::CMD_SETX, '0, $urandom, '0, '0, 1'b0);
      send_command(tvce_pkg::CMD_LEFT, '0, '0, '0, 16'($urandom), 1'b0);
      send_command(tvce_pkg::CMD_PUSH, '0, '0, '0, '0, 1'b0);
    end
    for (int i = 0; i < StackDepth + 2; i++) send_simple(tvce_pkg::CMD_POP, $urandom);
  endtask

  // Receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    hold_cycles = 300;
    hold_off = 1'b1;
    for (int i = 0; i < 12; i++) send_simple(tvce_pkg::CMD_JUMP, $urandom);
  endtask

  task automatic test_random_commands(input int count);
    logic [3:0] cmd;
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 20) cmd = tvce_pkg::CMD_STEP;
      else if (pick < 30) cmd = tvce_pkg::CMD_PUSH;
      else if (pick < 40) cmd = tvce_pkg::CMD_POP;
      else if (pick < 43) cmd = 4'($urandom_range(12, 15));
      else cmd = 4'($urandom_range(0, 11));
      send_command(cmd, rand_coord(), rand_coord(), rand_coord(), 16'($urandom),
                   1'($urandom));
    end
  endtask

  // Result checker
  always @(posedge clk) begin
    turtle_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[211:0];
      if (expected_results.size() == 0) begin
        $display("error: result item with nothing expected");
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (got.seg !== want.seg) report_mismatch("segment_valid", got.seg, want.seg);
        if (got.x0 !== want.x0) report_mismatch("seg_x0", got.x0, want.x0);
        if (got.y0 !== want.y0) report_mismatch("seg_y0", got.y0, want.y0);
        if (got.x1 !== want.x1) report_mismatch("seg_x1", got.x1, want.x1);
        if (got.y1 !== want.y1) report_mismatch("seg_y1", got.y1, want.y1);
        if (got.pos_x !== want.pos_x) report_mismatch("pos_x", got.pos_x, want.pos_x);
        if (got.pos_y !== want.pos_y) report_mismatch("pos_y", got.pos_y, want.pos_y);
        if (got.heading !== want.heading)
          report_mismatch("heading", got.heading, want.heading);
        if (got.pen !== want.pen) report_mismatch("pen", got.pen, want.pen);
        if (got.err !== want.err) report_mismatch("error_code", got.err, want.err);
      end
    end
  end

  // Result ready: long hold-off when asked, else random stall bursts while idle bursts are on
  initial begin
    int gap;
    out_tready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_off) begin
        out_tready = 1'b0;
        repeat (hold_cycles) @(negedge clk);
        hold_off = 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_tready = 1'b0;
        gap = $urandom_range(1, 19);
        repeat (gap) @(negedge clk);
      end else begin
        out_tready = 1'b1;
        @(negedge clk);
      end
    end
  end

  // Watchdog on cycles with no accepted item
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("turtle_vector_command_engine: mismatch");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    error_count = 0;
    idle_cycles = 0;
    idle_on = 1'b1;
    hold_off = 1'b0;
    hold_cycles = 0;
    start_x_q = '0; start_y_q = '0; start_head_q = '0; start_pen_q = 1'b0;
    turtle_x = '0; turtle_y = '0; turtle_head = '0; turtle_pen = 1'b0;
    depth_used = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed_commands();
    test_stack_limits();
    test_backpressure();
    test_random_commands(600);
    set_start($urandom, $urandom, 16'($urandom), 1'b1);
    send_simple(tvce_pkg::CMD_RESET, 32'h0);
    test_random_commands(600);
    set_start(32'h80000000, 32'h7FFFFFFF, 16'h0, 1'b0);
    send_simple(tvce_pkg::CMD_RESET, 32'h0);
    idle_on = 1'b0;
    test_random_commands(400);
    drain_results();
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("turtle_vector_command_engine: match");
    end else begin
      $display("turtle_vector_command_engine: mismatch");
    end
    $finish;
  end

endmodule
